[rtl/bb3_pkg.sv]
// Shared types, constants and helper functions of the 3x3 box blur.
package bb3_pkg;

  localparam int unsigned MAX_WIDTH_DEF = 1024;
  localparam int unsigned PIX_W         = 8;
  localparam int unsigned CFG_WIDTH_W   = 11;
  localparam int unsigned CFG_HEIGHT_W  = 16;
  localparam int unsigned ROW_W         = 17;
  localparam int unsigned SUM_W         = 12;
  localparam int unsigned SUMN_W        = 13;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned RECIP_SHIFT   = 18;
  localparam int unsigned RECIP_W       = 18;
  localparam int unsigned PROD_W        = SUMN_W + RECIP_W;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned DATA_W        = 32;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 16'd480;

  // Register index codes, taken from paddr[2].
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  // Request type codes.
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
  } pix_t;

  // One window column; index 0 is the oldest row.
  typedef pix_t [2:0] col_t;

  typedef struct packed {
    logic             req_type;
    logic             frame_start;
    logic [PIX_W-1:0] in_red;
    logic [PIX_W-1:0] in_green;
    logic [PIX_W-1:0] in_blue;
  } blur_req_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_red;
    logic [PIX_W-1:0] out_green;
    logic [PIX_W-1:0] out_blue;
    logic             image_last;
  } blur_res_t;

  // Number of window taps inside the image; never zero.
  function automatic logic [CNT_W-1:0] mean_count(logic [2:0] rmask, logic [2:0] cmask);
    logic [1:0]       nr;
    logic [1:0]       nc;
    logic [CNT_W-1:0] prod;
    nr   = 2'(rmask[0]) + 2'(rmask[1]) + 2'(rmask[2]);
    nc   = 2'(cmask[0]) + 2'(cmask[1]) + 2'(cmask[2]);
    prod = CNT_W'(nr) * CNT_W'(nc);
    if (prod == '0) begin
      prod = CNT_W'(1);
    end
    return prod;
  endfunction

  // Rounded-up reciprocal of twice the count, scaled by 2^RECIP_SHIFT. It is
  // exact for every dividend below 2^SUMN_W.
  function automatic logic [RECIP_W-1:0] mean_recip(logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] m;
    case (count)
      4'd1:    m = 18'd131072;
      4'd2:    m = 18'd65536;
      4'd3:    m = 18'd43691;
      4'd4:    m = 18'd32768;
      4'd6:    m = 18'd21846;
      4'd9:    m = 18'd14564;
      default: m = 18'd131072;
    endcase
    return m;
  endfunction

endpackage

[rtl/bb3_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module bb3_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/bb3_cell.sv]
// One column cell of the blur window; shifts its column to the left neighbour.
module bb3_cell import bb3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic shift_i,
  input  col_t col_i,
  output col_t col_o
);

  col_t col_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else if (shift_i) begin
      col_q <= col_i;
    end
  end

  assign col_o = col_q;

endmodule

[rtl/box_blur_3x3_edge_aware.sv]
// Streaming 3x3 edge-aware box blur of RGB888 pixels in raster order.
//
// Input requests arrive on in_valid_i/in_stall_o with a blur_req_t payload:
// a pixel request carries one pixel, frame_start marks the first pixel of an
// image, and a drain request carries no pixel and flushes the tail of the
// image. Results leave on out_valid_o/out_stall_i as blur_res_t; image_last
// marks the final pixel of the image. Output pixel p appears for the request
// at raster index p + width + 1, so width + 1 drain requests end an image.
// Each request is handled by a sequencer: a request that yields a result
// goes through line-buffer read, window shift, masked sum and reciprocal
// multiply into the output register, one that only fills the window ends
// after the window shift, and an ignored request is taken with no effect.
// in_stall_o is high while the sequencer is busy; requests wait for idle.
// A stalled result waits in the output register; the next request is still
// taken and processed, and only its result waits for the register to free.
// Reset clears the window and all positions and loads width 640, height 480;
// the line buffers need no clearing, as every entry is written before use.
// The registers are written over the APB port at byte addresses 0 and 4.
module box_blur_3x3_edge_aware import bb3_pkg::*; #(
  parameter int unsigned MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  blur_req_t         in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output blur_res_t         out_res_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int unsigned WW  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned XW  = WW + 1;
  localparam int unsigned CLW = $clog2(MAX_WIDTH);
  localparam int unsigned CW  = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WIN  = 2'd1;
  localparam logic [1:0] ST_SUM  = 2'd2;
  localparam logic [1:0] ST_MUL  = 2'd3;

  logic [CFG_WIDTH_W-1:0]  cfg_width_q;
  logic [CFG_HEIGHT_W-1:0] cfg_height_q;
  logic [CLW-1:0]          in_col_q, in_col_d, out_col_q, out_col_d;
  logic [ROW_W-1:0]        in_row_q, in_row_d, out_row_q, out_row_d;
  logic [1:0]              state_q, state_d;
  logic [CLW-1:0]          col_q;
  pix_t                    pix_q;
  logic                    emit_q, last_q;
  logic [2:0]              rmask_q, cmask_q;
  logic [SUMN_W-1:0]       nr_q, ng_q, nb_q;
  logic [RECIP_W-1:0]      recip_q;
  logic                    out_vld_q, out_vld_d;
  blur_res_t               out_res_q;

  logic [CW-1:0]           cfg_w_ext;
  logic [WW-1:0]           w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [ROW_W-1:0]        h_ext;
  logic [XW-1:0]           w_x;

  logic                    acc, drain, fs, take, emit_c, last_c;
  logic [CLW-1:0]          ic, oc;
  logic [ROW_W-1:0]        ir, orow;
  logic [XW-1:0]           ic_x, oc_x, ic_next, oc_next;
  logic                    wrap, owrap;
  logic [2:0]              rmask_c, cmask_c;

  logic [2*PIX_W*3-1:0]    line_rd;
  pix_t                    up_rd, mid_rd;
  col_t                    new_col;
  col_t                    feed  [3];
  col_t                    win   [3];
  logic                    win_shift;

  logic [SUM_W-1:0]        sum_r, sum_g, sum_b;
  logic [CNT_W-1:0]        count_c;
  logic                    out_load;
  logic [PROD_W-1:0]       prod_r, prod_g, prod_b;

  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= WIDTH_RESET;
      cfg_height_q <= HEIGHT_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_IMAGE_WIDTH:  cfg_width_q  <= pwdata[CFG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT: cfg_height_q <= pwdata[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_IMAGE_WIDTH:  prdata = DATA_W'(cfg_width_q);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(cfg_height_q);
      default:          prdata = '0;
    endcase
  end

  // Effective image size.
  assign cfg_w_ext = CW'(cfg_width_q);
  always_comb begin
    if (cfg_width_q == '0) begin
      w_eff = WW'(1);
    end else if (cfg_w_ext > CW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(cfg_w_ext);
    end
  end
  assign h_eff = (cfg_height_q == '0) ? CFG_HEIGHT_W'(1) : cfg_height_q;
  assign h_ext = ROW_W'(h_eff);
  assign w_x   = XW'(w_eff);

  // Request decode: a frame start on a pixel restarts every position.
  assign acc   = in_valid_i && (state_q == ST_IDLE);
  assign drain = (in_req_i.req_type == REQ_DRAIN);
  assign fs    = in_req_i.frame_start && !drain;
  assign take  = drain ? ((in_row_q >= h_ext) && (out_row_q < h_ext))
                       : (fs || (in_row_q < h_ext));

  assign ic   = fs ? '0 : in_col_q;
  assign ir   = fs ? '0 : in_row_q;
  assign oc   = fs ? '0 : out_col_q;
  assign orow = fs ? '0 : out_row_q;
  assign ic_x = XW'(ic);
  assign oc_x = XW'(oc);

  // The output trails the input by one row and one pixel.
  assign emit_c = (orow < h_ext) &&
                  ((ir >= ROW_W'(2)) ||
                   ((ir == ROW_W'(1)) && (ic != '0)) ||
                   ((ir == '0) && (ic_x > w_x)));

  assign ic_next  = ic_x + XW'(1);
  assign wrap     = ic_next >= w_x;
  assign in_col_d = wrap ? '0 : CLW'(ic_next);
  assign in_row_d = wrap ? ir + ROW_W'(1) : ir;

  assign oc_next   = oc_x + XW'(1);
  assign owrap     = oc_next >= w_x;
  assign out_col_d = emit_c ? (owrap ? '0 : CLW'(oc_next)) : oc;
  assign out_row_d = (emit_c && owrap) ? orow + ROW_W'(1) : orow;

  // Which window rows and columns lie inside the image.
  assign rmask_c[0] = (orow != '0) && ((orow - ROW_W'(1)) < h_ext);
  assign rmask_c[1] = orow < h_ext;
  assign rmask_c[2] = (orow + ROW_W'(1)) < h_ext;
  assign cmask_c[0] = (oc != '0) && ((oc_x - XW'(1)) < w_x);
  assign cmask_c[1] = oc_x < w_x;
  assign cmask_c[2] = (oc_x + XW'(1)) < w_x;
  assign last_c     = (orow == (h_ext - ROW_W'(1))) && (oc_x == (w_x - XW'(1)));

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (acc && take) state_d = ST_WIN;
      ST_WIN:  state_d = emit_q ? ST_SUM : ST_IDLE;
      ST_SUM:  state_d = ST_MUL;
      ST_MUL:  if (out_load) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      emit_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      if (acc && take) begin
        in_col_q  <= in_col_d;
        in_row_q  <= in_row_d;
        out_col_q <= out_col_d;
        out_row_q <= out_row_d;
        emit_q    <= emit_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc && take) begin
      col_q   <= ic;
      pix_q   <= drain ? '0 : pix_t'{in_req_i.in_red, in_req_i.in_green, in_req_i.in_blue};
      last_q  <= last_c;
      rmask_q <= rmask_c;
      cmask_q <= cmask_c;
    end
  end

  // Line buffers: upper row in the high half, middle row in the low half.
  bb3_ram #(
    .WIDTH (2 * PIX_W * 3),
    .DEPTH (MAX_WIDTH)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WIN),
    .waddr_i (col_q),
    .wdata_i ({mid_rd, pix_q}),
    .re_i    (acc && take),
    .raddr_i (ic),
    .rdata_o (line_rd)
  );

  assign up_rd  = line_rd[2*PIX_W*3-1:PIX_W*3];
  assign mid_rd = line_rd[PIX_W*3-1:0];

  assign new_col[0] = up_rd;
  assign new_col[1] = mid_rd;
  assign new_col[2] = pix_q;
  assign win_shift  = (state_q == ST_WIN);

  // Window: three column cells, the newest column on the right.
  for (genvar c = 0; c < 3; c++) begin : g_cells
    if (c == 2) begin : g_head
      assign feed[c] = new_col;
    end else begin : g_link
      assign feed[c] = win[c+1];
    end
    bb3_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (win_shift),
      .col_i   (feed[c]),
      .col_o   (win[c])
    );
  end

  // Masked sums over the window taps inside the image.
  always_comb begin
    sum_r = '0;
    sum_g = '0;
    sum_b = '0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (rmask_q[r] && cmask_q[c]) begin
          sum_r = sum_r + SUM_W'(win[c][r].red);
          sum_g = sum_g + SUM_W'(win[c][r].green);
          sum_b = sum_b + SUM_W'(win[c][r].blue);
        end
      end
    end
  end

  assign count_c = mean_count(rmask_q, cmask_q);

  // Half-up rounding: (2*sum + count) / (2*count), by reciprocal.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SUM) begin
      nr_q    <= {sum_r, 1'b0} + SUMN_W'(count_c);
      ng_q    <= {sum_g, 1'b0} + SUMN_W'(count_c);
      nb_q    <= {sum_b, 1'b0} + SUMN_W'(count_c);
      recip_q <= mean_recip(count_c);
    end
  end

  assign prod_r = PROD_W'(nr_q) * PROD_W'(recip_q);
  assign prod_g = PROD_W'(ng_q) * PROD_W'(recip_q);
  assign prod_b = PROD_W'(nb_q) * PROD_W'(recip_q);

  // Output register.
  assign out_load  = (state_q == ST_MUL) && (!out_vld_q || !out_stall_i);
  assign out_vld_d = out_load || (out_vld_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_res_q.out_red    <= prod_r[RECIP_SHIFT +: PIX_W];
      out_res_q.out_green  <= prod_g[RECIP_SHIFT +: PIX_W];
      out_res_q.out_blue   <= prod_b[RECIP_SHIFT +: PIX_W];
      out_res_q.image_last <= last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_res_o   = out_res_q;

endmodule
